>>> hw/rtl/enms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enms_pkg
// shared widths, register codes, result types and direction sectors for the
// edge non-maximum suppression block
// ----------------------------------------------------------------------------
package enms_pkg;

   localparam int MAX_COLS_DEF = 1024;
   localparam int MAX_ROWS_DEF = 1024;

   localparam int MAG_W     = 16;
   localparam int ANG_W     = 16;
   localparam int COORD_W   = 10;
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 1;
   localparam int MIN_DIM   = 3;
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

   localparam int LINE_W = ANG_W + 2 * MAG_W;

   // pi/8 multiples in q2.13
   localparam int SECT_P1 = 3216;
   localparam int SECT_P3 = 9650;
   localparam int SECT_P5 = 16084;
   localparam int SECT_P7 = 22518;

   localparam int PUSH_MAX    = 3;
   localparam int PUSH_W      = 2;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int RSV_W       = QCNT_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_ROWS = 1'b0,
      CSR_FRAME_COLS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_HORZ    = 2'd0,
      DIR_DIAG_UR = 2'd1,
      DIR_DIAG_UL = 2'd2,
      DIR_VERT    = 2'd3
   } dir_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_col;
      logic [MAG_W-1:0]   value;
      logic               last;
   } rsp_entry_type;

   // transaction in flight between line store read and window update
   typedef struct packed {
      logic                    vld;
      logic [PUSH_W-1:0]       n;
      logic                    dec;
      logic                    dec_border;
      logic                    emit_edge;
      logic [COORD_W-1:0]      row;
      logic [COORD_W-1:0]      col;
      logic [MAG_W-1:0]        mag;
      logic signed [ANG_W-1:0] ang;
   } stage_type;

   function automatic dir_type sector(input logic signed [ANG_W-1:0] a);
      dir_type d;
      if ((a >= -SECT_P1 && a <= SECT_P1) || a >= SECT_P7 + 1 || a <= -(SECT_P7 + 1)) begin
         d = DIR_HORZ;
      end else if ((a >= SECT_P1 + 1 && a <= SECT_P3) ||
                   (a >= -SECT_P7 && a <= -(SECT_P5 + 1))) begin
         d = DIR_DIAG_UR;
      end else if ((a >= SECT_P5 + 1 && a <= SECT_P7) ||
                   (a >= -SECT_P3 && a <= -(SECT_P1 + 1))) begin
         d = DIR_DIAG_UL;
      end else begin
         d = DIR_VERT;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/enms_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enms channel interfaces
// valid/ready channels for pixel transactions in and result transactions out
// ----------------------------------------------------------------------------
interface enms_req_if;
   import enms_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [MAG_W-1:0]        magnitude;
   logic signed [ANG_W-1:0] angle;

   modport source (output valid, output magnitude, output angle, input ready);
   modport sink   (input valid, input magnitude, input angle, output ready);
endinterface

interface enms_rsp_if;
   import enms_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] out_row;
   logic [COORD_W-1:0] out_col;
   logic [MAG_W-1:0]   value;
   logic               last;

   modport source (output valid, output out_row, output out_col, output value,
                   output last, input ready);
   modport sink   (input valid, input out_row, input out_col, input value,
                   input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/edge_non_max_suppression.sv
`default_nettype none
// ----------------------------------------------------------------------------
// edge_non_max_suppression
// canny non-maximum suppression over a raster stream of gradient magnitude
// and angle, 3x3 window from a line store ram, border pixels passed through
//
//   channel   direction   carries
//   req_ch    in          magnitude, angle (one pixel per transaction)
//   rsp_ch    out         out_row, out_col, value, last (one result each)
//   csr_*     in          frame_rows (index 0), frame_cols (index 1)
//
// one pixel transaction per clock while req_ch.ready is high; results are queued
// the result port gives one result per clock while rsp_ch.ready is high, so
// row ends (two results) and the last row (two, three at the frame end) are
// limited by that port; reset clears counters, window and result queue; the
// line store ram is not cleared and needs no pass after reset
// req_ch.ready drops when the 8-entry result queue plus reserved slots is full
// ----------------------------------------------------------------------------
module edge_non_max_suppression #(
   parameter int MAX_COLS = enms_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = enms_pkg::MAX_ROWS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   enms_req_if.sink                          req_ch,
   enms_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [enms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [enms_pkg::CFG_W-1:0]        csr_wdata
);
   import enms_pkg::*;

   localparam int CW = $clog2(MAX_COLS);
   localparam int RW = $clog2(MAX_ROWS);

   logic [CFG_W-1:0] frame_rows_ff;
   logic [CFG_W-1:0] frame_rows_in;
   logic [CFG_W-1:0] frame_cols_ff;
   logic [CFG_W-1:0] frame_cols_in;
   logic [RW-1:0]    row_ff;
   logic [RW-1:0]    row_in;
   logic [CW-1:0]    col_ff;
   logic [CW-1:0]    col_in;
   logic [RW-1:0]    rows_last;
   logic [CW-1:0]    cols_last;
   logic             end_row;
   logic             end_frame;
   logic [PUSH_W-1:0] n_next;
   logic             req_fire;
   logic [RSV_W-1:0] reserved;

   stage_type        s1_ff;
   stage_type        s1_in;
   logic [CW-1:0]    s1_addr_ff;
   logic [CW-1:0]    s1_addr_in;

   logic [LINE_W-1:0]       rd_data;
   logic [MAG_W-1:0]        rd_older;
   logic [MAG_W-1:0]        rd_prev;
   logic signed [ANG_W-1:0] rd_ang;
   logic [LINE_W-1:0]       wr_data;

   logic [PUSH_W-1:0]                   push_n;
   rsp_entry_type [PUSH_MAX-1:0]        push_data;
   logic                                q_valid;
   rsp_entry_type                       q_head;
   logic [QCNT_W-1:0]                   q_count;
   logic                                rsp_fire;

   // configuration registers
   always_comb begin
      frame_rows_in = frame_rows_ff;
      frame_cols_in = frame_cols_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_ROWS: frame_rows_in = csr_wdata;
            CSR_FRAME_COLS: frame_cols_in = csr_wdata;
            default: begin
               frame_rows_in = frame_rows_ff;
               frame_cols_in = frame_cols_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_rows_ff <= CFG_RESET;
         frame_cols_ff <= CFG_RESET;
      end else begin
         frame_rows_ff <= frame_rows_in;
         frame_cols_ff <= frame_cols_in;
      end
   end

   // clamped last indices
   always_comb begin
      if (frame_rows_ff < CFG_W'(MIN_DIM)) begin
         rows_last = RW'(MIN_DIM - 1);
      end else if (32'(frame_rows_ff) > 32'(MAX_ROWS)) begin
         rows_last = RW'(MAX_ROWS - 1);
      end else begin
         rows_last = RW'(frame_rows_ff - CFG_W'(1));
      end
      if (frame_cols_ff < CFG_W'(MIN_DIM)) begin
         cols_last = CW'(MIN_DIM - 1);
      end else if (32'(frame_cols_ff) > 32'(MAX_COLS)) begin
         cols_last = CW'(MAX_COLS - 1);
      end else begin
         cols_last = CW'(frame_cols_ff - CFG_W'(1));
      end
   end

   // raster position and results owed by the next transaction
   always_comb begin
      end_row   = (col_ff >= cols_last);
      end_frame = (row_ff >= rows_last);
      n_next    = PUSH_W'(row_ff != '0 && col_ff != '0) +
                  PUSH_W'(row_ff != '0 && end_row) +
                  PUSH_W'(end_frame);
      reserved  = RSV_W'(q_count) + RSV_W'(s1_ff.n) + RSV_W'(n_next);
   end

   assign req_ch.ready = (reserved <= RSV_W'(QUEUE_DEPTH));
   assign req_fire     = req_ch.valid & req_ch.ready;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (req_fire) begin
         if (end_row) begin
            col_in = '0;
            row_in = end_frame ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // stage register aligned with the line store read
   always_comb begin
      s1_in      = s1_ff;
      s1_addr_in = s1_addr_ff;
      s1_in.vld  = req_fire;
      s1_in.n    = req_fire ? n_next : '0;
      if (req_fire) begin
         s1_in.dec        = (row_ff != '0 && col_ff != '0);
         s1_in.dec_border = (row_ff == RW'(1) || col_ff == CW'(1));
         s1_in.emit_edge  = (row_ff != '0 && end_row);
         s1_in.row        = COORD_W'(row_ff);
         s1_in.col        = COORD_W'(col_ff);
         s1_in.mag        = req_ch.magnitude;
         s1_in.ang        = req_ch.angle;
         s1_addr_in       = col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
         s1_ff.n   <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= s1_addr_in;
   end

   // line store word: angle, previous line, older line
   assign rd_older = rd_data[MAG_W-1:0];
   assign rd_prev  = rd_data[2*MAG_W-1:MAG_W];
   assign rd_ang   = rd_data[LINE_W-1:2*MAG_W];
   assign wr_data  = {s1_ff.ang, s1_ff.mag, rd_prev};

   enms_line_store #(
      .DEPTH (MAX_COLS)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (s1_ff.vld),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data)
   );

   enms_window u_window (
      .clock     (clock),
      .reset     (reset),
      .s1        (s1_ff),
      .rd_older  (rd_older),
      .rd_prev   (rd_prev),
      .rd_ang    (rd_ang),
      .push_n    (push_n),
      .push_data (push_data)
   );

   assign rsp_fire = q_valid & rsp_ch.ready;

   enms_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_n     (push_n),
      .push_data  (push_data),
      .pop        (rsp_fire),
      .head_valid (q_valid),
      .head_data  (q_head),
      .count      (q_count)
   );

   assign rsp_ch.valid   = q_valid;
   assign rsp_ch.out_row = q_head.out_row;
   assign rsp_ch.out_col = q_head.out_col;
   assign rsp_ch.value   = q_head.value;
   assign rsp_ch.last    = q_head.last;

   // read-modify-write never reads the column being written back
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.vld && req_fire) |-> (s1_addr_ff != col_ff))
      else $error("line store read and write hit the same column");

   // slots reserved at accept always cover the results pushed
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (RSV_W'(q_count) + RSV_W'(push_n)) <= RSV_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // input only stalls while results are pending
   a_no_deadlock: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (q_count != '0 || s1_ff.vld))
      else $error("input stalled with nothing pending");

endmodule
`default_nettype wire

>>> hw/rtl/enms_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enms_line_store
// line store ram holding older magnitude, previous magnitude and previous
// angle per column; one write and one registered read per cycle
// ----------------------------------------------------------------------------
module enms_line_store #(
   parameter int DEPTH = enms_pkg::MAX_COLS_DEF
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [enms_pkg::LINE_W-1:0] rd_data,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [enms_pkg::LINE_W-1:0] wr_data
);
   import enms_pkg::*;

   logic [LINE_W-1:0] mem [DEPTH];
   logic [LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/enms_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enms_window
// 3x3 magnitude window, direction sector and local maximum test; builds up to
// three result entries per transaction
// ----------------------------------------------------------------------------
module enms_window (
   input  logic                                                clock,
   input  logic                                                reset,
   input  enms_pkg::stage_type                                 s1,
   input  logic [enms_pkg::MAG_W-1:0]                          rd_older,
   input  logic [enms_pkg::MAG_W-1:0]                          rd_prev,
   input  logic signed [enms_pkg::ANG_W-1:0]                   rd_ang,
   output logic [enms_pkg::PUSH_W-1:0]                         push_n,
   output enms_pkg::rsp_entry_type [enms_pkg::PUSH_MAX-1:0]    push_data
);
   import enms_pkg::*;

   // window columns 1 and 2 before the shift; column 0 is never needed later
   logic [MAG_W-1:0]        win_mid_ff   [3];
   logic [MAG_W-1:0]        win_mid_in   [3];
   logic [MAG_W-1:0]        win_right_ff [3];
   logic [MAG_W-1:0]        win_right_in [3];
   logic signed [ANG_W-1:0] center_ang_ff;
   logic signed [ANG_W-1:0] center_ang_in;

   logic [MAG_W-1:0] center;
   logic [MAG_W-1:0] nb1;
   logic [MAG_W-1:0] nb2;
   logic [MAG_W-1:0] dec_value;
   rsp_entry_type    e_dec;
   rsp_entry_type    e_edge;
   rsp_entry_type    e_self;

   always_comb begin
      win_mid_in    = win_mid_ff;
      win_right_in  = win_right_ff;
      center_ang_in = center_ang_ff;
      if (s1.vld) begin
         win_mid_in      = win_right_ff;
         win_right_in[0] = rd_older;
         win_right_in[1] = rd_prev;
         win_right_in[2] = s1.mag;
         center_ang_in   = rd_ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            win_mid_ff[i]   <= '0;
            win_right_ff[i] <= '0;
         end
         center_ang_ff <= '0;
      end else begin
         win_mid_ff    <= win_mid_in;
         win_right_ff  <= win_right_in;
         center_ang_ff <= center_ang_in;
      end
   end

   // neighbours in the shifted window
   always_comb begin
      center = win_right_ff[1];
      case (sector(center_ang_ff))
         DIR_HORZ: begin
            nb1 = win_mid_ff[1];
            nb2 = rd_prev;
         end
         DIR_DIAG_UR: begin
            nb1 = rd_older;
            nb2 = win_mid_ff[2];
         end
         DIR_DIAG_UL: begin
            nb1 = win_mid_ff[0];
            nb2 = s1.mag;
         end
         DIR_VERT: begin
            nb1 = win_right_ff[0];
            nb2 = win_right_ff[2];
         end
         default: begin
            nb1 = win_right_ff[0];
            nb2 = win_right_ff[2];
         end
      endcase
      if (s1.dec_border || (center > nb1 && center > nb2)) begin
         dec_value = center;
      end else begin
         dec_value = '0;
      end
   end

   always_comb begin
      e_dec.out_row  = s1.row - COORD_W'(1);
      e_dec.out_col  = s1.col - COORD_W'(1);
      e_dec.value    = dec_value;
      e_dec.last     = 1'b0;
      e_edge.out_row = s1.row - COORD_W'(1);
      e_edge.out_col = s1.col;
      e_edge.value   = rd_prev;
      e_edge.last    = 1'b0;
      e_self.out_row = s1.row;
      e_self.out_col = s1.col;
      e_self.value   = s1.mag;
      e_self.last    = 1'b0;

      if (s1.dec) begin
         push_data[0] = e_dec;
      end else if (s1.emit_edge) begin
         push_data[0] = e_edge;
      end else begin
         push_data[0] = e_self;
      end
      if (s1.dec && s1.emit_edge) begin
         push_data[1] = e_edge;
      end else begin
         push_data[1] = e_self;
      end
      push_data[2] = e_self;

      push_data[0].last = (s1.n == PUSH_W'(1));
      push_data[1].last = (s1.n == PUSH_W'(2));
      push_data[2].last = (s1.n == PUSH_W'(3));

      push_n = s1.vld ? s1.n : '0;
   end

endmodule
`default_nettype wire

>>> hw/rtl/enms_rsp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// enms_rsp_queue
// result queue taking up to three entries per cycle and giving one when popped
// ----------------------------------------------------------------------------
module enms_rsp_queue (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic [enms_pkg::PUSH_W-1:0]                      push_n,
   input  enms_pkg::rsp_entry_type [enms_pkg::PUSH_MAX-1:0] push_data,
   input  logic                                             pop,
   output logic                                             head_valid,
   output enms_pkg::rsp_entry_type                          head_data,
   output logic [enms_pkg::QCNT_W-1:0]                      count
);
   import enms_pkg::*;

   rsp_entry_type     q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
      count_in  = count_ff + QCNT_W'(push_n) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PUSH_MAX; i++) begin
         if (i < int'(push_n)) begin
            q_ff[wr_ptr_ff + QPTR_W'(i)] <= push_data[i];
         end
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = q_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for edge_non_max_suppression: pixel transactions are
// fed in raster order, each accepted pixel runs through a behavioral model of
// the line stores, 3x3 window and direction sectors, and every result
// transaction is compared field by field against the oldest expected result.
// covers register clamping, mid-frame reshaping, sector boundaries, and
// random frames under source idling and sink backpressure
// ----------------------------------------------------------------------------
module tb_top;
   import enms_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 10;
   localparam int NUM_EDGES = 19;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   enms_req_if req_ch ();
   enms_rsp_if rsp_ch ();

   edge_non_max_suppression dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model state
   logic [CFG_W-1:0]        cfg_rows;
   logic [CFG_W-1:0]        cfg_cols;
   logic [MAG_W-1:0]        mag_older [MAX_COLS_DEF];
   logic [MAG_W-1:0]        mag_prev [MAX_COLS_DEF];
   logic signed [ANG_W-1:0] ang_prev [MAX_COLS_DEF];
   logic [MAG_W-1:0]        win_mag [9];
   logic signed [ANG_W-1:0] center_ang;
   int unsigned             row_cnt;
   int unsigned             col_cnt;

   rsp_entry_type pending_results [$];

   int sector_edges [NUM_EDGES] = '{0, 3216, 3217, -3216, -3217, 9650, 9651, -9650, -9651,
                                    16084, 16085, -16084, -16085, 22518, 22519, -22518,
                                    -22519, 25736, -25736};

   int idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   int pixel_count = 0;
   int result_count = 0;
   int csr_write_count = 0;
   int cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic dir_type classify_angle(input int a);
      if ((a >= -SECT_P1 && a <= SECT_P1) || a > SECT_P7 || a < -SECT_P7) return DIR_HORZ;
      if ((a > SECT_P1 && a <= SECT_P3) || (a >= -SECT_P7 && a < -SECT_P5)) return DIR_DIAG_UR;
      if ((a > SECT_P5 && a <= SECT_P7) || (a >= -SECT_P3 && a < -SECT_P1)) return DIR_DIAG_UL;
      return DIR_VERT;
   endfunction

   function automatic logic [MAG_W-1:0] suppress_center(input logic signed [ANG_W-1:0] ang);
      logic [MAG_W-1:0] n1;
      logic [MAG_W-1:0] n2;
      case (classify_angle(int'(ang)))
         DIR_HORZ: begin
            n1 = win_mag[3];
            n2 = win_mag[5];
         end
         DIR_DIAG_UR: begin
            n1 = win_mag[2];
            n2 = win_mag[6];
         end
         DIR_DIAG_UL: begin
            n1 = win_mag[0];
            n2 = win_mag[8];
         end
         default: begin
            n1 = win_mag[1];
            n2 = win_mag[7];
         end
      endcase
      if (win_mag[4] > n1 && win_mag[4] > n2) return win_mag[4];
      return '0;
   endfunction

   function automatic rsp_entry_type pixel_result(input int unsigned r, input int unsigned c,
                                                  input logic [MAG_W-1:0] v);
      rsp_entry_type res;
      res.out_row = COORD_W'(r);
      res.out_col = COORD_W'(c);
      res.value   = v;
      res.last    = 1'b0;
      return res;
   endfunction

   task automatic predict_pixel(input logic [MAG_W-1:0] mag, input logic signed [ANG_W-1:0] ang);
      int unsigned             n_rows;
      int unsigned             n_cols;
      int unsigned             r;
      int unsigned             c;
      int unsigned             idx;
      logic signed [ANG_W-1:0] ang_used;
      logic                    end_row;
      logic                    end_frame;
      logic [MAG_W-1:0]        v;
      rsp_entry_type           emitted [$];
      n_rows = clamp_dim(cfg_rows, MAX_ROWS_DEF);
      n_cols = clamp_dim(cfg_cols, MAX_COLS_DEF);
      r = row_cnt;
      c = col_cnt;
      idx = c % MAX_COLS_DEF;
      ang_used = center_ang;
      end_row = (c >= n_cols - 1);
      end_frame = (r >= n_rows - 1);
      for (int i = 0; i < 3; i++) begin
         win_mag[i*3]   = win_mag[i*3+1];
         win_mag[i*3+1] = win_mag[i*3+2];
      end
      win_mag[2] = mag_older[idx];
      win_mag[5] = mag_prev[idx];
      win_mag[8] = mag;
      center_ang = ang_prev[idx];
      ang_prev[idx] = ang;
      mag_older[idx] = mag_prev[idx];
      mag_prev[idx] = mag;
      if (r >= 1 && c >= 1) begin
         if (r == 1 || c == 1) v = win_mag[4];
         else v = suppress_center(ang_used);
         emitted.push_back(pixel_result(r - 1, c - 1, v));
      end
      if (r >= 1 && end_row) emitted.push_back(pixel_result(r - 1, c, win_mag[5]));
      if (end_frame) emitted.push_back(pixel_result(r, c, mag));
      if (emitted.size() > 0) emitted[emitted.size()-1].last = 1'b1;
      foreach (emitted[k]) pending_results.push_back(emitted[k]);
      if (end_row) begin
         col_cnt = 0;
         row_cnt = end_frame ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
      end
   endtask

   function automatic void check_field(input string field, input logic [MAG_W-1:0] exp_val,
                                       input logic [MAG_W-1:0] act_val);
      if (act_val !== exp_val) begin
         error_count++;
         if (error_count <= 40)
            $display("%0t mismatch %s expected %0d actual %0d", $time, field, exp_val, act_val);
      end
   endfunction

   always @(posedge clock) begin
      rsp_entry_type exp_res;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         result_count++;
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= 40)
               $display("%0t unexpected transaction expected none actual row %0d col %0d value %0d",
                        $time, rsp_ch.out_row, rsp_ch.out_col, rsp_ch.value);
         end else begin
            exp_res = pending_results.pop_front();
            check_field("out_row", MAG_W'(exp_res.out_row), MAG_W'(rsp_ch.out_row));
            check_field("out_col", MAG_W'(exp_res.out_col), MAG_W'(rsp_ch.out_col));
            check_field("value", exp_res.value, rsp_ch.value);
            check_field("last", MAG_W'(exp_res.last), MAG_W'(rsp_ch.last));
         end
      end
   end

   function automatic logic [MAG_W-1:0] rand_magnitude();
      int sel;
      sel = $urandom_range(99);
      if (sel < 30) return MAG_W'($urandom_range(3));
      if (sel < 40) return ($urandom_range(1) != 0) ? '1 : '0;
      return MAG_W'($urandom);
   endfunction

   function automatic logic signed [ANG_W-1:0] rand_angle();
      int a;
      if ($urandom_range(99) < 40) a = sector_edges[$urandom_range(NUM_EDGES - 1)];
      else a = int'($urandom_range(51472)) - 25736;
      return a[ANG_W-1:0];
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FRAME_ROWS) cfg_rows = data;
      else cfg_cols = data;
      csr_write_count++;
   endtask

   task automatic send_pixel(input logic [MAG_W-1:0] mag, input logic signed [ANG_W-1:0] ang);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.magnitude <= mag;
      req_ch.angle     <= ang;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_pixel(mag, ang);
      pixel_count++;
   endtask

   task automatic send_random_pixels(input int n);
      repeat (n) send_pixel(rand_magnitude(), rand_angle());
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // reset dimensions first, then undersized writes clamp up and cut the row and frame short
   task automatic test_clamp_low();
      send_random_pixels(5);
      drain_results();
      write_csr(CSR_FRAME_COLS, CFG_W'(0));
      send_random_pixels(13);
      drain_results();
      write_csr(CSR_FRAME_ROWS, CFG_W'(1));
      send_random_pixels(3);
      drain_results();
   endtask

   // an oversized column write clamps to the maximum, then both dimensions shrink mid-frame
   task automatic test_clamp_high();
      write_csr(CSR_FRAME_ROWS, CFG_W'(1024));
      write_csr(CSR_FRAME_COLS, CFG_W'(2047));
      send_random_pixels(6);
      drain_results();
      write_csr(CSR_FRAME_COLS, CFG_W'(3));
      send_random_pixels(7);
      drain_results();
      write_csr(CSR_FRAME_ROWS, CFG_W'(2));
      send_random_pixels(3);
      drain_results();
   endtask

   // sector boundary angles cycle over a 5x7 frame, some on interior pixels; magnitudes chosen to tie
   task automatic test_direction_sectors();
      logic [MAG_W-1:0] tie_mags [4];
      tie_mags = '{16'd0, 16'd1, 16'hFFFE, 16'hFFFF};
      write_csr(CSR_FRAME_ROWS, CFG_W'(5));
      write_csr(CSR_FRAME_COLS, CFG_W'(7));
      for (int i = 0; i < 35; i++)
         send_pixel(tie_mags[$urandom_range(3)], sector_edges[i % NUM_EDGES][ANG_W-1:0]);
      drain_results();
   endtask

   task automatic test_streaming(input int src_idle, input int sink_stall, input int rows,
                                 input int cols, input int n_items);
      int sent;
      bit paused;
      sent = 0;
      paused = 1'b0;
      write_csr(CSR_FRAME_ROWS, CFG_W'(rows));
      write_csr(CSR_FRAME_COLS, CFG_W'(cols));
      idle_pct = src_idle;
      stall_pct = sink_stall;
      while (sent < n_items) begin
         for (int p = 0; p < rows * cols; p++) begin
            if (!paused && sent == n_items / 2) begin
               drain_results();
               paused = 1'b1;
            end
            send_pixel(rand_magnitude(), rand_angle());
            sent++;
         end
      end
      drain_results();
      idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_FRAME_ROWS;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.magnitude = '0;
      req_ch.angle     = '0;
      rsp_ch.ready     = 1'b1;
      cfg_rows   = CFG_RESET;
      cfg_cols   = CFG_RESET;
      center_ang = '0;
      row_cnt    = 0;
      col_cnt    = 0;
      foreach (win_mag[i]) win_mag[i] = '0;
      for (int i = 0; i < MAX_COLS_DEF; i++) begin
         mag_older[i] = '0;
         mag_prev[i]  = '0;
         ang_prev[i]  = '0;
      end
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_clamp_low();
      test_clamp_high();
      test_direction_sectors();
      test_streaming(0, 0, 3, 3, 25);
      test_streaming(87, 0, $urandom_range(4, 8), $urandom_range(4, 10), 25);
      test_streaming(0, 87, $urandom_range(4, 8), $urandom_range(4, 10), 25);
      test_streaming(14, 14, $urandom_range(3, 8), $urandom_range(3, 10), 25);

      $display("covered %0d pixel transactions, %0d result transactions, %0d register writes",
               pixel_count, result_count, csr_write_count);
      $display("frame shapes from 3x3 up to clamped 1024, all sector edges, idle and stall mixes");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/enms_pkg.sv
hw/rtl/enms_if.sv
hw/rtl/enms_line_store.sv
hw/rtl/enms_window.sv
hw/rtl/enms_rsp_queue.sv
hw/rtl/edge_non_max_suppression.sv
dv/tb_top.sv
